// ===== design/csd_pkg.sv =====
// Shared types and constants for the COBS stream deframer.
package csd_pkg;

  localparam int unsigned MAX_FRAME_DEF = 256;
  localparam logic [7:0] DELIM_BYTE = 8'h00;

  typedef enum logic [1:0] {
    SYNC_WAIT_DELIM = 2'd0,
    SYNC_WAIT_CODE  = 2'd1,
    SYNC_RUNNING    = 2'd2
  } sync_t;

  typedef enum logic [1:0] {
    EV_BYTE    = 2'd0,
    EV_END     = 2'd1,
    EV_OVERRUN = 2'd2
  } event_t;

  typedef struct packed {
    event_t      ev;
    logic [7:0]  data;
    logic [7:0]  index;
    logic [8:0]  length;
    logic [31:0] overruns;
  } result_t;

endpackage

// ===== design/cobs_stream_deframer.sv =====
// Top level of the COBS stream deframer.
// Decodes a COBS-framed byte stream (0x00 delimits frames) and reports
// decoded bytes with their index, frame ends with their length, and receiver
// overruns with a wrapping 32-bit count. For each accepted request the
// sync/skip/position state updates in the accepting cycle and any result is
// written into a two-entry output queue, so one request per clock is
// sustained while the output side keeps up. in_stall rises only when the
// queue holds two results. Frames longer than MAX_FRAME keep decoding but
// drop the excess bytes.
module cobs_stream_deframer import csd_pkg::*; #(
  parameter int unsigned MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  event_res,
  output logic [7:0]  payload_byte,
  output logic [7:0]  payload_index,
  output logic [8:0]  frame_length,
  output logic [31:0] overrun_count
);

  logic    accept;
  logic    res_valid;
  logic    full;
  result_t res;
  result_t out_res;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  csd_decode #(
    .MAX_FRAME(MAX_FRAME)
  ) u_decode (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .kind     (kind),
    .rx_byte  (rx_byte),
    .res_valid(res_valid),
    .res      (res)
  );

  csd_out_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (res_valid),
    .push_res (res),
    .full     (full),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_res  (out_res)
  );

  assign event_res     = 2'(out_res.ev);
  assign payload_byte  = out_res.data;
  assign payload_index = out_res.index;
  assign frame_length  = out_res.length;
  assign overrun_count = out_res.overruns;

endmodule

// ===== design/csd_decode.sv =====
// COBS decode state and combinational step logic for one received request.
module csd_decode import csd_pkg::*; #(
  parameter int unsigned MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic       kind,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  output result_t    res
);

  localparam int unsigned PW = $clog2(MAX_FRAME + 1);

  sync_t          sync_state, sync_state_next;
  logic [7:0]     skip_count, skip_count_next;
  logic [PW-1:0]  position, position_next;
  logic [31:0]    overruns, overruns_next;
  logic [7:0]     skip_dec;
  logic [15:0]    pos_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_state <= SYNC_WAIT_DELIM;
      skip_count <= '0;
      position   <= '0;
      overruns   <= '0;
    end else begin
      sync_state <= sync_state_next;
      skip_count <= skip_count_next;
      position   <= position_next;
      overruns   <= overruns_next;
    end
  end

  assign skip_dec = skip_count - 8'd1;
  assign pos_ext  = 16'(position);

  always_comb begin
    sync_state_next = sync_state;
    skip_count_next = skip_count;
    position_next   = position;
    overruns_next   = overruns;
    res_valid       = 1'b0;
    res.ev          = EV_BYTE;
    res.data        = '0;
    res.index       = '0;
    res.length      = '0;
    res.overruns    = overruns;
    if (accept) begin
      if (kind) begin
        overruns_next   = overruns + 32'd1;
        position_next   = '0;
        sync_state_next = SYNC_WAIT_DELIM;
        res_valid       = 1'b1;
        res.ev          = EV_OVERRUN;
        res.overruns    = overruns + 32'd1;
      end else if (rx_byte == DELIM_BYTE) begin
        sync_state_next = SYNC_WAIT_CODE;
        position_next   = '0;
        if (sync_state != SYNC_WAIT_DELIM) begin
          res_valid  = 1'b1;
          res.ev     = EV_END;
          res.length = pos_ext[8:0];
        end
      end else begin
        case (sync_state)
          SYNC_WAIT_DELIM: begin
          end
          SYNC_WAIT_CODE: begin
            skip_count_next = rx_byte;
            sync_state_next = SYNC_RUNNING;
          end
          SYNC_RUNNING: begin
            if (skip_dec == 8'd0) begin
              skip_count_next = rx_byte;
              res.data        = '0;
            end else begin
              skip_count_next = skip_dec;
              res.data        = rx_byte;
            end
            // drop bytes once the frame is full
            if (position < PW'(MAX_FRAME)) begin
              res_valid     = 1'b1;
              res.ev        = EV_BYTE;
              res.index     = pos_ext[7:0];
              position_next = position + PW'(1);
            end
          end
          default: begin
            sync_state_next = SYNC_WAIT_DELIM;
          end
        endcase
      end
    end
  end

endmodule

// ===== design/csd_out_queue.sv =====
// Two-entry result queue that decouples the output stall from input acceptance.
module csd_out_queue import csd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_res,
  output logic    full,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_res
);

  result_t    slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign pop       = out_valid && !out_stall;
  assign out_res   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== test/cobs_stream_deframer_tb.sv =====
// Testbench for cobs_stream_deframer: random COBS frames, noise and overruns.
module cobs_stream_deframer_tb;
  import csd_pkg::*;

  localparam int unsigned FRAME_CAP = MAX_FRAME_DEF;
  localparam int STUCK_LIMIT = 2000;
  localparam int HOLD_CYCLES = 200;
  localparam int RANDOM_REQUESTS = 240;

  class cobs_decode_checker;
    sync_t sync_st;
    logic [7:0] skip;
    logic [8:0] pos;
    logic [31:0] overruns;
    result_t pending_results[$];
    int errors;

    function new();
      sync_st = SYNC_WAIT_DELIM;
      skip = '0;
      pos = '0;
      overruns = '0;
      errors = 0;
    endfunction

    function void note_request(logic k, logic [7:0] b);
      result_t r;
      logic [7:0] d;
      r = '0;
      if (k) begin
        overruns = overruns + 1;
        pos = '0;
        sync_st = SYNC_WAIT_DELIM;
        r.ev = EV_OVERRUN;
        r.overruns = overruns;
        pending_results.push_back(r);
        return;
      end
      if (b == DELIM_BYTE) begin
        if (sync_st != SYNC_WAIT_DELIM) begin
          r.ev = EV_END;
          r.length = pos;
          r.overruns = overruns;
          pending_results.push_back(r);
        end
        sync_st = SYNC_WAIT_CODE;
        pos = '0;
        return;
      end
      if (sync_st == SYNC_WAIT_DELIM) return;
      if (sync_st == SYNC_WAIT_CODE) begin
        skip = b;
        sync_st = SYNC_RUNNING;
        return;
      end
      d = b;
      skip = skip - 8'd1;
      if (skip == 8'd0) begin
        skip = b;
        d = 8'h00;
      end
      if (pos >= FRAME_CAP) return;
      r.ev = EV_BYTE;
      r.data = d;
      r.index = pos[7:0];
      r.overruns = overruns;
      pending_results.push_back(r);
      pos = pos + 9'd1;
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        if (errors < 10)
          $display("unexpected result: ev=%0d byte=%02h idx=%0d len=%0d ovr=%0d",
                   got.ev, got.data, got.index, got.length, got.overruns);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.ev !== want.ev || got.data !== want.data || got.index !== want.index ||
          got.length !== want.length || got.overruns !== want.overruns) begin
        if (errors < 10) begin
          $display("mismatch: expected ev=%0d byte=%02h idx=%0d len=%0d ovr=%0d",
                   want.ev, want.data, want.index, want.length, want.overruns);
          $display("          got      ev=%0d byte=%02h idx=%0d len=%0d ovr=%0d",
                   got.ev, got.data, got.index, got.length, got.overruns);
        end
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic kind = 1'b0;
  logic [7:0] rx_byte = 8'h00;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] event_res;
  logic [7:0] payload_byte;
  logic [7:0] payload_index;
  logic [8:0] frame_length;
  logic [31:0] overrun_count;

  cobs_decode_checker dec_chk = new();
  result_t seen_result;
  bit quiet_in = 1'b0;
  bit quiet_out = 1'b0;
  bit hold_output = 1'b0;
  int requests_sent = 0;
  int stuck_cycles = 0;

  cobs_stream_deframer #(.MAX_FRAME(FRAME_CAP)) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .kind(kind),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .event_res(event_res),
    .payload_byte(payload_byte),
    .payload_index(payload_index),
    .frame_length(frame_length),
    .overrun_count(overrun_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        dec_chk.note_request(kind, rx_byte);
      end
      if (out_valid && !out_stall) begin
        seen_result = '{event_t'(event_res), payload_byte, payload_index, frame_length,
                        overrun_count};
        dec_chk.check_result(seen_result);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        stuck_cycles <= 0;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  function automatic logic [7:0] pick_code();
    case ($urandom_range(0, 9))
      0: return 8'hFF;
      1: return 8'h01;
      default: return 8'($urandom_range(2, 12));
    endcase
  endfunction

  task automatic send_request(input logic k, input logic [7:0] b);
    int gap;
    gap = quiet_in ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    requests_sent++;
  endtask

  // delimiter, code byte, then nonzero bytes with group codes at each reload
  task automatic send_frame(input int n, input logic [7:0] first_code);
    int cnt;
    logic [7:0] b;
    send_request(1'b0, DELIM_BYTE);
    send_request(1'b0, first_code);
    cnt = first_code;
    repeat (n) begin
      cnt--;
      if (cnt == 0) begin
        b = pick_code();
        cnt = b;
      end else begin
        b = 8'($urandom_range(1, 255));
      end
      send_request(1'b0, b);
    end
  endtask

  initial begin
    int wait_cycles;
    wait (rst == 1'b0);
    forever begin
      if (hold_output) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_output = 1'b0;
      end
      wait_cycles = quiet_out ? 0 : $urandom_range(0, 14);
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    int start_count;
    int n;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_request(1'b1, 8'hA5);
    send_request(1'b0, 8'h41);
    send_request(1'b0, DELIM_BYTE);
    send_request(1'b0, DELIM_BYTE);
    send_request(1'b0, 8'hFF);
    send_request(1'b0, 8'h01);
    send_request(1'b0, 8'h80);
    send_request(1'b0, 8'hFF);
    send_request(1'b0, DELIM_BYTE);
    send_request(1'b0, 8'h01);
    send_request(1'b0, 8'h03);
    send_request(1'b0, 8'h7F);
    send_request(1'b0, 8'hFE);
    send_request(1'b0, 8'h02);
    send_request(1'b0, 8'h55);
    send_request(1'b1, 8'h00);
    send_request(1'b0, 8'h12);
    send_request(1'b0, DELIM_BYTE);
    send_request(1'b0, 8'h02);
    send_request(1'b0, DELIM_BYTE);
    send_request(1'b0, DELIM_BYTE);

    // overflow the frame buffer; first code runs its full count
    send_frame(300, 8'hFF);

    // back up the output while input keeps coming
    quiet_in = 1'b1;
    hold_output = 1'b1;
    send_frame(40, pick_code());
    quiet_in = 1'b0;

    start_count = requests_sent;
    while (requests_sent - start_count < RANDOM_REQUESTS) begin
      quiet_in = ($urandom_range(0, 4) == 0);
      quiet_out = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 19))
        0: send_request(1'b1, 8'($urandom()));
        1: begin
          repeat ($urandom_range(1, 6))
            send_request($urandom_range(0, 15) == 0, 8'($urandom()));
        end
        2: begin
          send_frame($urandom_range(0, 10), pick_code());
          send_request(1'b1, 8'($urandom()));
        end
        default: begin
          n = ($urandom_range(0, 29) == 0) ? $urandom_range(100, 270)
                                           : $urandom_range(0, 24);
          send_frame(n, pick_code());
        end
      endcase
    end
    send_request(1'b0, DELIM_BYTE);
    in_valid <= 1'b0;
    quiet_out = 1'b0;

    while (dec_chk.pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (dec_chk.errors == 0 && dec_chk.pending_results.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
